/* rtl/bmhq_pkg.sv */
// Shared types and codes for the binary min-heap queue.
package bmhq_pkg;

    localparam int unsigned OP_W = 2;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned ST_W = 2;
    localparam int unsigned CNT_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Command travelling from the controller through the storage cells.
    typedef struct packed {
        logic load;    // shift a new item in
        logic minus;   // drop the top item
        logic del;     // delete the first match
    } t_cmd;

    // Signed less-than on raw patterns.
    function automatic logic lt_s(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        lt_s = $signed(a) < $signed(b);
    endfunction

endpackage

/* rtl/bmhq_cell.sv */
// One storage cell of the sorted chain; together the cells hold the heap contents in order.
module bmhq_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmhq_pkg::t_cmd              i_cmd,
    input  logic [bmhq_pkg::VAL_W-1:0]  i_new,
    input  logic                        i_found,
    input  logic                        i_prev_valid,
    input  logic [bmhq_pkg::VAL_W-1:0]  i_prev_data,
    input  logic                        i_prev_gt,
    input  logic                        i_next_valid,
    input  logic [bmhq_pkg::VAL_W-1:0]  i_next_data,
    output logic                        o_valid,
    output logic [bmhq_pkg::VAL_W-1:0]  o_data,
    output logic                        o_gt,
    output logic                        o_eq
);
    import bmhq_pkg::*;

    logic             r_valid;
    logic [VAL_W-1:0] r_data;
    logic             n_valid;
    logic [VAL_W-1:0] n_data;
    logic             w_gt;
    logic             w_ge;

    // This cell's item is strictly greater than the new one: it moves down.
    // The chain is sorted, so a greater neighbor above means this cell moves too.
    assign w_gt    = r_valid && lt_s(i_new, r_data);
    // At or past the first match of a delete, every filled cell holds >= the value.
    assign w_ge    = r_valid && !lt_s(r_data, i_new);
    assign o_gt    = w_gt;
    assign o_eq    = r_valid && (r_data == i_new);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_cmd.load) begin
            if (i_prev_gt) begin
                n_valid = i_prev_valid;
                n_data  = i_prev_data;
            end else if (w_gt || (!r_valid && i_prev_valid)) begin
                n_valid = 1'b1;
                n_data  = i_new;
            end
        end else if (i_cmd.minus || (i_cmd.del && i_found && w_ge)) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

endmodule

/* rtl/binary_min_heap_queue_top.sv */
// Top level of the min-heap priority queue: request control and the cell chain.
//
//  channel  | dir | tdata fields (low to high)          | tuser
//  s_axis   | in  | value[31:0]                         | op[1:0]
//  m_axis   | out | status[1:0] taken_value[33:2] count[44:34] | -
//
// A request is registered when accepted and applied across the cells in the
// busy state that follows; its result is then offered from the output register.
// The next request is taken the cycle after the result leaves, so only one
// request is in flight for every op, and an output stall holds off the next one.
// The DEPTH cells update in parallel, every cell trading with its neighbors.
// Reset empties all cells at once.
module binary_min_heap_queue_top #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0] taken_value[33:2] count[44:34]
);
    import bmhq_pkg::*;

    localparam int unsigned NW = $clog2(DEPTH + 1);

    t_cmd               r_cmd;
    logic [VAL_W-1:0]   r_val;
    logic               r_busy;
    logic [NW-1:0]      r_cnt;
    logic               r_ovalid;
    logic [ST_W-1:0]    r_status;
    logic [VAL_W-1:0]   r_taken;
    logic [NW-1:0]      r_ocnt;
    t_cmd               n_cmd;
    logic [ST_W-1:0]    n_status;

    logic [DEPTH:0]             w_valid;
    logic [VAL_W-1:0]           w_data [DEPTH+1];
    logic [DEPTH:0]             w_gt;
    logic [DEPTH-1:0]           w_eq;
    logic                       w_found;
    logic                       w_acc;
    t_op                        w_op;

    // slot ahead of the first cell counts as filled so an empty chain loads cell 0
    assign w_valid[0] = 1'b1;
    assign w_data[0]  = '0;
    assign w_gt[0]    = 1'b0;
    assign w_found    = |w_eq;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic             w_nv;
            logic [VAL_W-1:0] w_nd;
            if (g == DEPTH - 1) begin : g_end
                assign w_nv = 1'b0;
                assign w_nd = '0;
            end else begin : g_mid
                assign w_nv = w_valid[g+2];
                assign w_nd = w_data[g+2];
            end
            bmhq_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_cmd(r_cmd), .i_new(r_val), .i_found(w_found),
                .i_prev_valid(w_valid[g]), .i_prev_data(w_data[g]),
                .i_prev_gt(w_gt[g]),
                .i_next_valid(w_nv), .i_next_data(w_nd),
                .o_valid(w_valid[g+1]), .o_data(w_data[g+1]),
                .o_gt(w_gt[g+1]), .o_eq(w_eq[g])
            );
        end
    endgenerate

    assign s_axis_tready = !r_busy && !r_ovalid;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_op  = t_op'(s_axis_tuser);

    always_comb begin
        n_cmd    = '0;
        n_status = ST_OK;
        case (w_op)
            OP_INSERT: begin
                if (r_cnt >= NW'(DEPTH)) n_status = ST_FULL;
                else n_cmd.load = 1'b1;
            end
            OP_POP: begin
                if (r_cnt == '0) n_status = ST_EMPTY;
                else n_cmd.minus = 1'b1;
            end
            OP_REMOVE: begin
                if (r_cnt == '0) n_status = ST_EMPTY;
                else n_cmd.del = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= '0;
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else if (w_acc) begin
            r_busy   <= 1'b1;
            r_cmd    <= n_cmd;
            r_val    <= s_axis_tdata;
            r_taken  <= '0;
            r_status <= n_status;
        end else if (r_busy) begin
            r_busy   <= 1'b0;
            r_cmd    <= '0;
            r_ovalid <= 1'b1;
            if (r_cmd.load) begin
                r_cnt  <= r_cnt + NW'(1);
                r_ocnt <= r_cnt + NW'(1);
            end else if (r_cmd.minus) begin
                r_taken <= w_data[1];
                r_cnt   <= r_cnt - NW'(1);
                r_ocnt  <= r_cnt - NW'(1);
            end else if (r_cmd.del) begin
                if (w_found) begin
                    r_taken <= r_val;
                    r_cnt   <= r_cnt - NW'(1);
                    r_ocnt  <= r_cnt - NW'(1);
                end else begin
                    r_status <= ST_NOTFOUND;
                    r_ocnt   <= r_cnt;
                end
            end else begin
                r_ocnt <= r_cnt;
            end
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, CNT_W'(r_ocnt), r_taken, r_status};

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH)) else $error("count above depth");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_cmd) <= 1) else $error("several commands");
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != '0) |-> r_busy) else $error("command while idle");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_ovalid) else $error("result lost");
`endif

endmodule
